// File: hw/rtl/chained_int_hash_table_macros.svh
// Assertion macros for the chained integer hash table.
// Used by the top level; needs no other file.
`ifndef CHAINED_INT_HASH_TABLE_MACROS_SVH
`define CHAINED_INT_HASH_TABLE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CIH_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication outside reset.
`define CIH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: hw/rtl/cih_pkg.sv
// Package for the chained integer hash table: commands, status codes, types.
// No dependencies.
`default_nettype none
package cih_pkg;
	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_LOOKUP = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;

	typedef struct packed {
		logic [1:0]  command;
		logic signed [31:0] key;
		logic [31:0] value;
	} req_t;

	typedef struct packed {
		logic [31:0] read_value;
		logic        found;
		logic [1:0]  status;
	} rsp_t;
endpackage
`default_nettype wire

// File: hw/rtl/cih_if.sv
// Valid/ready channel interfaces for the hash table.
// No dependencies.
`default_nettype none
interface cih_req_if;
	logic         valid;
	logic         ready;
	logic [1:0]   command;
	logic signed [31:0] key;
	logic [31:0]  value;
	modport source (output valid, command, key, value, input ready);
	modport sink (input valid, command, key, value, output ready);
endinterface

interface cih_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_value;
	logic        found;
	logic [1:0]  status;
	modport source (output valid, read_value, found, status, input ready);
	modport sink (input valid, read_value, found, status, output ready);
endinterface

interface cih_cfg_if;
	logic       valid;
	logic       ready;
	logic [8:0] bucket_count;
	modport source (output valid, bucket_count, input ready);
	modport sink (input valid, bucket_count, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/chained_int_hash_table.sv
// Chained integer hash table top level: modulo unit, sequencer, memories.
// Depends on cih_pkg, cih_if and chained_int_hash_table_macros.svh.
//
//  channel | dir | payload
//  req     | in  | command, key, value
//  rsp     | out | read_value, found, status
//  cfg     | in  | bucket_count
//
// One request at a time. The bucket index is found by a restoring divider,
// one quotient bit per cycle. Then each chain hop is a memory read followed
// by a compare; an insert also walks to the chain tail.
// After reset, and on clear, the valid bits are cleared and an init pass
// rebuilds the free list; no request is taken meanwhile.
// The result sits in an output register; the next request waits until taken.
`default_nettype none
`include "chained_int_hash_table_macros.svh"
module chained_int_hash_table #(
	parameter int BUCKETS = 256,
	parameter int POOL    = 256
) (
	input  wire logic clk,
	input  wire logic arst_n,
	cih_req_if.sink   req,
	cih_rsp_if.source rsp,
	cih_cfg_if.sink   cfg
);
	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int PW = (POOL > 1) ? $clog2(POOL) : 1;
	localparam int LW = $clog2(POOL + 1);
	localparam int CW = $clog2(((BUCKETS > POOL) ? BUCKETS : POOL) + 1);
	localparam logic [LW-1:0] LINK_END = LW'(POOL);
	localparam logic [LW-1:0] POOL_N = LW'(POOL);

	typedef enum logic [10:0] {
		S_INIT   = 11'b00000000001,
		S_IDLE   = 11'b00000000010,
		S_DIV    = 11'b00000000100,
		S_HREAD  = 11'b00000001000,
		S_HEAD   = 11'b00000010000,
		S_NREAD  = 11'b00000100000,
		S_NODE   = 11'b00001000000,
		S_PROMO  = 11'b00010000000,
		S_POPRD  = 11'b00100000000,
		S_POP    = 11'b01000000000,
		S_OUT    = 11'b10000000000
	} state_t;

	state_t state_q;

	// memories
	logic [31:0]   bkey_mem [BUCKETS];
	logic [31:0]   bdat_mem [BUCKETS];
	logic [LW-1:0] bnxt_mem [BUCKETS];
	logic [31:0]   nkey_mem [POOL];
	logic [31:0]   ndat_mem [POOL];
	logic [LW-1:0] nnxt_mem [POOL];
	logic [PW-1:0] free_mem [POOL];
	logic [BUCKETS-1:0] bvalid_q;

	logic [8:0]  bcount_q;
	logic [LW-1:0] fcount_q;
	cih_pkg::req_t req_q;
	cih_pkg::rsp_t rsp_q;
	logic        rsp_valid_q;
	logic [CW-1:0] init_q;

	// divider
	logic [31:0] dquo_q;
	logic [8:0]  drem_q;
	logic [5:0]  dcnt_q;
	logic [8:0]  modv;
	logic [9:0]  dtrial;
	logic [BW-1:0] bkt_q;

	// chain walk
	logic [LW-1:0] prev_q, cur_q, newn_q;
	logic [31:0]   bkey_rd, bdat_rd, nkey_rd, ndat_rd;
	logic [LW-1:0] bnxt_rd, nnxt_rd;
	logic [PW-1:0] free_rd;

	// memory request signals
	logic          b_we, n_we, nn_we, f_we;
	logic [BW-1:0] b_addr;
	logic [31:0]   b_wkey, b_wdat;
	logic [LW-1:0] b_wnxt;
	logic [PW-1:0] n_addr, nn_addr, f_addr;
	logic [31:0]   n_wkey, n_wdat;
	logic [LW-1:0] nn_wnxt;
	logic [PW-1:0] f_wdat;

	logic          keq_head, keq_node;

	always_comb begin
		modv = bcount_q;
		if (modv == 9'd0) modv = 9'd1;
		if (32'(modv) > 32'(BUCKETS)) modv = 9'(BUCKETS);
	end
	assign dtrial = {drem_q, dquo_q[31]} - {1'b0, modv};
	assign keq_head = (bkey_rd == req_q.key);
	assign keq_node = (nkey_rd == req_q.key);

	assign req.ready = (state_q == S_IDLE) && !rsp_valid_q;
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.read_value = rsp_q.read_value;
	assign rsp.found = rsp_q.found;
	assign rsp.status = rsp_q.status;

	// bucket memories, one read/write port
	always_ff @(posedge clk) begin
		if (b_we) begin
			bkey_mem[b_addr] <= b_wkey;
			bdat_mem[b_addr] <= b_wdat;
			bnxt_mem[b_addr] <= b_wnxt;
		end
		bkey_rd <= bkey_mem[b_addr];
		bdat_rd <= bdat_mem[b_addr];
		bnxt_rd <= bnxt_mem[b_addr];
	end

	// node memories; key/data and link have separate write addresses
	always_ff @(posedge clk) begin
		if (n_we) begin
			nkey_mem[n_addr] <= n_wkey;
			ndat_mem[n_addr] <= n_wdat;
		end
		if (nn_we) nnxt_mem[nn_addr] <= nn_wnxt;
		nkey_rd <= nkey_mem[n_addr];
		ndat_rd <= ndat_mem[n_addr];
		nnxt_rd <= nnxt_mem[n_addr];
	end

	// free stack
	always_ff @(posedge clk) begin
		if (f_we) free_mem[f_addr] <= f_wdat;
		free_rd <= free_mem[f_addr];
	end

	// memory port control
	always_comb begin
		b_we = 1'b0; n_we = 1'b0; nn_we = 1'b0; f_we = 1'b0;
		b_addr = bkt_q;
		b_wkey = req_q.key; b_wdat = req_q.value; b_wnxt = LINK_END;
		n_addr = cur_q[PW-1:0]; nn_addr = cur_q[PW-1:0];
		n_wkey = req_q.key; n_wdat = req_q.value; nn_wnxt = LINK_END;
		f_addr = fcount_q[PW-1:0]; f_wdat = cur_q[PW-1:0];
		unique case (state_q)
			S_INIT: begin
				f_we = (32'(init_q) < POOL);
				f_addr = init_q[PW-1:0];
				f_wdat = init_q[PW-1:0];
			end
			S_HEAD: begin
				if (req_q.command == cih_pkg::CMD_INSERT && !bvalid_q[bkt_q]) begin
					b_we = 1'b1;
				end else if (req_q.command == cih_pkg::CMD_REMOVE && keq_head
						&& bnxt_rd != LINK_END) begin
					n_addr = bnxt_rd[PW-1:0];
				end else begin
					n_addr = bnxt_rd[PW-1:0];
				end
				f_addr = PW'(fcount_q - LW'(1));
			end
			S_NODE: begin
				n_addr = nnxt_rd[PW-1:0];
				if (req_q.command == cih_pkg::CMD_REMOVE && keq_node) begin
					if (prev_q == LINK_END) begin
						b_we = 1'b1; b_wkey = bkey_rd; b_wdat = bdat_rd;
						b_wnxt = nnxt_rd;
					end else begin
						nn_we = 1'b1; nn_addr = prev_q[PW-1:0]; nn_wnxt = nnxt_rd;
					end
					f_we = (fcount_q < POOL_N);
				end
			end
			S_PROMO: begin
				b_we = 1'b1; b_wkey = nkey_rd; b_wdat = ndat_rd; b_wnxt = nnxt_rd;
				f_we = (fcount_q < POOL_N);
			end
			S_POPRD: begin
				// top of the free stack
				f_addr = PW'(fcount_q - LW'(1));
			end
			S_POP: begin
				// new node at the tail
				n_we = 1'b1; n_addr = free_rd; nn_we = 1'b1; nn_addr = free_rd;
				if (cur_q == LINK_END) begin
					b_we = 1'b1; b_wkey = bkey_rd; b_wdat = bdat_rd;
					b_wnxt = LW'(free_rd);
				end else begin
					n_we = 1'b1;
				end
			end
			S_OUT: begin
				// tail link fix-up after a pop (key/data written in S_POP)
				nn_we = (cur_q != LINK_END);
				nn_addr = cur_q[PW-1:0];
				nn_wnxt = newn_q;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			init_q <= '0;
			bvalid_q <= '0;
			fcount_q <= POOL_N;
			bcount_q <= 9'(BUCKETS);
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) bcount_q <= cfg.bucket_count;
			if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					init_q <= init_q + CW'(1);
					if (32'(init_q) >= ((BUCKETS > POOL) ? BUCKETS : POOL) - 1)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req.valid && req.ready) begin
						req_q <= '{req.command, req.key, req.value};
						rsp_q <= '{32'd0, 1'b0, cih_pkg::ST_DONE};
						if (req.command == cih_pkg::CMD_CLEAR) begin
							bvalid_q <= '0;
							fcount_q <= POOL_N;
							init_q <= '0;
							rsp_valid_q <= 1'b1;
							state_q <= S_INIT;
						end else begin
							dquo_q <= req.key;
							drem_q <= '0;
							dcnt_q <= '0;
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					// restoring division, one quotient bit a cycle
					dquo_q <= {dquo_q[30:0], 1'b0};
					if (!dtrial[9]) drem_q <= dtrial[8:0];
					else drem_q <= {drem_q[7:0], dquo_q[31]};
					dcnt_q <= dcnt_q + 6'd1;
					if (dcnt_q == 6'd31) state_q <= S_HREAD;
				end
				S_HREAD: begin
					state_q <= S_HEAD;
				end
				S_HEAD: begin
					prev_q <= LINK_END;
					cur_q <= bnxt_rd;
					case (req_q.command)
						cih_pkg::CMD_INSERT: begin
							if (!bvalid_q[bkt_q]) begin
								bvalid_q[bkt_q] <= 1'b1;
								rsp_valid_q <= 1'b1;
								state_q <= S_IDLE;
							end else if (fcount_q == '0) begin
								rsp_q.status <= cih_pkg::ST_FULL;
								rsp_valid_q <= 1'b1;
								state_q <= S_IDLE;
							end else if (bnxt_rd == LINK_END) begin
								state_q <= S_POPRD;
							end else begin
								state_q <= S_NODE;
							end
						end
						default: begin
							if (!bvalid_q[bkt_q]) begin
								rsp_q.status <= cih_pkg::ST_NOTFOUND;
								rsp_valid_q <= 1'b1;
								state_q <= S_IDLE;
							end else if (keq_head) begin
								if (req_q.command == cih_pkg::CMD_REMOVE) begin
									if (bnxt_rd == LINK_END) begin
										bvalid_q[bkt_q] <= 1'b0;
										rsp_valid_q <= 1'b1;
										state_q <= S_IDLE;
									end else begin
										state_q <= S_PROMO;
									end
								end else begin
									rsp_q.read_value <= bdat_rd;
									rsp_q.found <= (bdat_rd != 32'd0);
									rsp_q.status <= (bdat_rd != 32'd0) ?
										cih_pkg::ST_DONE : cih_pkg::ST_NOTFOUND;
									rsp_valid_q <= 1'b1;
									state_q <= S_IDLE;
								end
							end else if (bnxt_rd == LINK_END) begin
								rsp_q.status <= cih_pkg::ST_NOTFOUND;
								rsp_valid_q <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								state_q <= S_NODE;
							end
						end
					endcase
				end
				S_NREAD: begin
					state_q <= S_NODE;
				end
				S_NODE: begin
					prev_q <= cur_q;
					// an insert that reached the tail keeps it in cur_q
					cur_q <= (req_q.command == cih_pkg::CMD_INSERT && nnxt_rd == LINK_END) ?
						cur_q : nnxt_rd;
					if (req_q.command == cih_pkg::CMD_INSERT) begin
						if (nnxt_rd == LINK_END) state_q <= S_POPRD;
						else state_q <= S_NREAD;
					end else if (keq_node) begin
						if (req_q.command == cih_pkg::CMD_REMOVE) begin
							if (fcount_q < POOL_N) fcount_q <= fcount_q + LW'(1);
						end else begin
							rsp_q.read_value <= ndat_rd;
							rsp_q.found <= (ndat_rd != 32'd0);
							rsp_q.status <= (ndat_rd != 32'd0) ?
								cih_pkg::ST_DONE : cih_pkg::ST_NOTFOUND;
						end
						rsp_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else if (nnxt_rd == LINK_END) begin
						rsp_q.status <= cih_pkg::ST_NOTFOUND;
						rsp_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_NREAD;
					end
				end
				S_PROMO: begin
					if (fcount_q < POOL_N) fcount_q <= fcount_q + LW'(1);
					rsp_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_POPRD: begin
					fcount_q <= fcount_q - LW'(1);
					state_q <= S_POP;
				end
				S_POP: begin
					newn_q <= LW'(free_rd);
					state_q <= S_OUT;
				end
				S_OUT: begin
					rsp_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// bucket index capture at end of division
	always_ff @(posedge clk) begin
		if (state_q == S_DIV && dcnt_q == 6'd31) begin
			bkt_q <= BW'(dtrial[9] ? {drem_q[7:0], dquo_q[31]} : dtrial[8:0]);
		end
	end

	`CIH_ASSERT(a_no_req_busy, req.valid && req.ready, state_q == S_IDLE, "request taken while busy")
	`CIH_ASSERT_NEXT(a_rsp_hold, rsp.valid && !rsp.ready, rsp.valid, "result dropped")
	`CIH_ASSERT(a_fcount_rng, 1'b1, fcount_q <= POOL_N, "free count above pool size")
endmodule
`default_nettype wire
